[rtl/tbs_pkg.sv]
// Package for the texture bilinear sampler: beat types, codes, sizes and
// the structure passed from the address stage to the blend unit.
// No dependencies.
package tbs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int BANK_AW    = XW + YW - 2;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;
  localparam int FRAC_W     = 16;
  localparam int WGT_W      = 2 * FRAC_W + 1;
  localparam int SCALE_W    = XW + FRAC_W;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indices.
  localparam logic [1:0] REG_TEX_WIDTH     = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_FILTER_ENABLE = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  texel_x;
    logic [7:0]  texel_y;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [16:0] coord_u;
    logic [16:0] coord_v;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  // Neighbour order: 0 = (x1,y1), 1 = (x1,y2), 2 = (x2,y1), 3 = (x2,y2).
  typedef struct packed {
    logic [3:0][23:0]      texel;
    logic [3:0][WGT_W-1:0] weight;
  } blend_req_t;

endpackage

[rtl/tbs_bank.sv]
// One texel memory bank: one write port and one registered read port.
// Depends on tbs_pkg for the bank depth and address width.
module tbs_bank (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [tbs_pkg::BANK_AW-1:0] rd_addr,
  output logic [23:0]              rd_data,
  input  logic                     wr_en,
  input  logic [tbs_pkg::BANK_AW-1:0] wr_addr,
  input  logic [23:0]              wr_data
);
  import tbs_pkg::*;

  logic [23:0] mem [BANK_DEPTH];

  // A read in the same cycle as a write to the same entry returns old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/tbs_blend.sv]
// Blend unit: weighted products of four texels, then sum, rounding and
// saturation into the result register. Depends on tbs_pkg.
module tbs_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                req_valid,
  input  tbs_pkg::blend_req_t req,
  output logic                res_valid,
  output tbs_pkg::out_item_t  res
);
  import tbs_pkg::*;

  localparam int PROD_W = 8 + WGT_W;
  localparam int ACC_W  = PROD_W + 1;

  logic [2:0][3:0][PROD_W-1:0] prod_r;
  logic [2:0][3:0][PROD_W-1:0] prod_nxt;
  logic                        prod_valid_r;
  logic [2:0][7:0]             chan_nxt;
  logic                        res_valid_r;
  out_item_t                   res_r;

  // Products of each channel byte with its neighbour weight.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_nxt[c][k] = PROD_W'(req.texel[k][8*(2-c) +: 8]) * PROD_W'(req.weight[k]);
      end
    end
  end

  // Sum, round to nearest and saturate each channel.
  always_comb begin
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] rnd;
    for (int c = 0; c < 3; c++) begin
      acc = ACC_W'(prod_r[c][0]) + ACC_W'(prod_r[c][1])
          + ACC_W'(prod_r[c][2]) + ACC_W'(prod_r[c][3]);
      rnd = (acc + (ACC_W'(1) << (2 * FRAC_W - 1))) >> (2 * FRAC_W);
      chan_nxt[c] = (rnd > ACC_W'(255)) ? 8'hFF : rnd[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= req_valid;
      res_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      res_r  <= '{out_red: chan_nxt[0], out_green: chan_nxt[1], out_blue: chan_nxt[2]};
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[rtl/texture_bilinear_sampler.sv]
// Top level of the texture bilinear sampler: configuration registers,
// coordinate scaling, banked texel memory and the blend unit.
// Depends on tbs_pkg, tbs_bank and tbs_blend.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes write beats,
// which store one RGB texel and give no result, and sample beats, which give
// one result beat on the output channel (out_valid, out_ready, out_data).
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle;
// the block itself does not enforce this. One beat is accepted every cycle
// unless the receiver stalls. A sample passes through registered steps: the
// coordinate scaling multiply is registered at acceptance, then comes the
// memory read, which reads all four neighbours at once from four banks split
// on column and row parity, then the weight products, and then the sum into
// the result register.
// A write issues in the same stage as sample reads, so a sample accepted in
// the cycle after a write already sees the new texel.
// When the receiver stalls the whole pipeline holds, and in_ready falls
// until the waiting result is taken. Reset empties the pipeline and loads
// width 256, height 256 and filtering on; texel memory is not cleared.
module texture_bilinear_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_wdata
);
  import tbs_pkg::*;

  logic [8:0] tex_width_r;
  logic [8:0] tex_height_r;
  logic       filter_r;

  logic       en;
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;
  logic [XW:0]   w_eff;
  logic [YW:0]   h_eff;

  // Stage one: scaled coordinates and write data.
  logic               p1_valid_r;
  logic               p1_cmd_r;
  logic [SCALE_W-1:0] su_r;
  logic [YW+FRAC_W-1:0] sv_r;
  logic [7:0]         wx_r;
  logic [7:0]         wy_r;
  logic [23:0]        wrgb_r;
  logic [16:0]        u_sat;
  logic [16:0]        v_sat;

  // Address stage signals.
  logic [XW-1:0]  x1;
  logic [YW-1:0]  y1;
  logic [XW-1:0]  x2;
  logic [YW-1:0]  y2;
  logic [XW:0]    x1_inc;
  logic [YW:0]    y1_inc;
  logic [FRAC_W-1:0] fu;
  logic [FRAC_W-1:0] fv;
  logic [SCALE_W-1:0] su_rnd;
  logic [YW+FRAC_W-1:0] sv_rnd;
  logic [FRAC_W:0] wx1;
  logic [FRAC_W:0] wy1;
  logic [3:0][WGT_W-1:0] wgt_nxt;

  // Stage two: weights, aligned with the memory read data.
  logic                  p2_valid_r;
  logic [3:0][WGT_W-1:0] wgt_r;
  logic                  x1p_r;
  logic                  y1p_r;
  logic [3:0][23:0]      bank_q;
  logic [3:0][BANK_AW-1:0] bank_ra;
  logic [3:0]            bank_we;
  blend_req_t            req;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= 9'd256;
      tex_height_r <= 9'd256;
      filter_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:     tex_width_r  <= cfg_wdata;
        REG_TEX_HEIGHT:    tex_height_r <= cfg_wdata;
        REG_FILTER_ENABLE: filter_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, oversize as the maximum.
  always_comb begin
    if (tex_width_r == 9'd0) begin
      w_eff = (XW+1)'(1);
    end else if (32'(tex_width_r) > MAX_WIDTH) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(tex_width_r);
    end
    if (tex_height_r == 9'd0) begin
      h_eff = (YW+1)'(1);
    end else if (32'(tex_height_r) > MAX_HEIGHT) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(tex_height_r);
    end
    wm1 = XW'(w_eff - (XW+1)'(1));
    hm1 = YW'(h_eff - (YW+1)'(1));
  end

  assign u_sat = in_data.coord_u[16] ? 17'h10000 : in_data.coord_u;
  assign v_sat = in_data.coord_v[16] ? 17'h10000 : in_data.coord_v;

  // Scaling multiply into stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_cmd_r <= in_data.cmd;
      su_r     <= SCALE_W'(u_sat * wm1);
      sv_r     <= (YW+FRAC_W)'(v_sat * hm1);
      wx_r     <= in_data.texel_x;
      wy_r     <= in_data.texel_y;
      wrgb_r   <= {in_data.in_red, in_data.in_green, in_data.in_blue};
    end
  end

  // Neighbour positions and weights; nearest mode is a single full weight.
  always_comb begin
    su_rnd = su_r + SCALE_W'(1 << (FRAC_W - 1));
    sv_rnd = sv_r + (YW+FRAC_W)'(1 << (FRAC_W - 1));
    if (filter_r) begin
      x1 = su_r[SCALE_W-1:FRAC_W];
      y1 = sv_r[YW+FRAC_W-1:FRAC_W];
      fu = su_r[FRAC_W-1:0];
      fv = sv_r[FRAC_W-1:0];
    end else begin
      x1 = su_rnd[SCALE_W-1:FRAC_W];
      y1 = sv_rnd[YW+FRAC_W-1:FRAC_W];
      fu = '0;
      fv = '0;
    end
    x1_inc = (XW+1)'(x1) + (XW+1)'(1);
    y1_inc = (YW+1)'(y1) + (YW+1)'(1);
    x2 = (x1_inc >= w_eff) ? '0 : x1_inc[XW-1:0];
    y2 = (y1_inc >= h_eff) ? '0 : y1_inc[YW-1:0];
    wx1 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(fu);
    wy1 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(fv);
    wgt_nxt[0] = WGT_W'(wx1 * wy1);
    wgt_nxt[1] = WGT_W'(wx1 * fv);
    wgt_nxt[2] = WGT_W'(fu * wy1);
    wgt_nxt[3] = WGT_W'(fu * fv);
  end

  // Bank b holds column parity b[0] and row parity b[1]. When both columns
  // share a parity the second one carries zero weight, so either serves.
  always_comb begin
    logic [XW-1:0] xa;
    logic [YW-1:0] ya;
    for (int b = 0; b < 4; b++) begin
      xa = (x1[0] == b[0]) ? x1 : x2;
      ya = (y1[0] == b[1]) ? y1 : y2;
      bank_ra[b] = {ya[YW-1:1], xa[XW-1:1]};
      bank_we[b] = en && p1_valid_r && (p1_cmd_r == CMD_WRITE)
                   && (wx_r[0] == b[0]) && (wy_r[0] == b[1]);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    tbs_bank u_bank (
      .clk     (clk),
      .rd_en   (en),
      .rd_addr (bank_ra[b]),
      .rd_data (bank_q[b]),
      .wr_en   (bank_we[b]),
      .wr_addr ({wy_r[YW-1:1], wx_r[XW-1:1]}),
      .wr_data (wrgb_r)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p2_valid_r <= p1_valid_r && (p1_cmd_r == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wgt_r <= wgt_nxt;
      x1p_r <= x1[0];
      y1p_r <= y1[0];
    end
  end

  // Route bank outputs to neighbour order. A neighbour with zero weight may
  // come from an entry outside the texture in use, so it is forced to zero.
  always_comb begin
    req.weight   = wgt_r;
    req.texel[0] = (wgt_r[0] == '0) ? '0 : bank_q[{y1p_r,  x1p_r}];
    req.texel[1] = (wgt_r[1] == '0) ? '0 : bank_q[{!y1p_r, x1p_r}];
    req.texel[2] = (wgt_r[2] == '0) ? '0 : bank_q[{y1p_r,  !x1p_r}];
    req.texel[3] = (wgt_r[3] == '0) ? '0 : bank_q[{!y1p_r, !x1p_r}];
  end

  tbs_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_valid (p2_valid_r),
    .req       (req),
    .res_valid (out_valid),
    .res       (out_data)
  );

  // The four weights always sum to exactly one.
  assert property (@(posedge clk) disable iff (!rst_n)
    p2_valid_r |-> (34'(wgt_r[0]) + 34'(wgt_r[1]) + 34'(wgt_r[2]) + 34'(wgt_r[3])
                    == 34'(64'd1 << (2 * FRAC_W))))
    else $error("bilinear weights do not sum to one");

  // Wrapped neighbours stay inside the texture in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && (p1_cmd_r == CMD_SAMPLE)
      |-> ((XW+1)'(x2) < w_eff) && ((YW+1)'(y2) < h_eff))
    else $error("neighbour index outside texture");

  // A write beat never reaches the blend stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    en && p1_valid_r && (p1_cmd_r == CMD_WRITE) |=> !p2_valid_r)
    else $error("write beat entered the blend stage");

  // Nothing moves through the pipeline while the result is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(p2_valid_r) && $stable(p1_valid_r))
    else $error("pipeline advanced during a stall");

endmodule
